FILE: design/bounded_ordered_list_engine_macros.svh
// Assertion helpers for the ordered list engine.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH

// Concurrent assertion on an explicit clock and reset.
`define BOLE_ASSERT(name, clk_s, rst_s, prop, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error(msg);

// Concurrent assertion on the local clk and rst.
`define BOLE_ASSERT_CR(name, prop, msg) \
  `BOLE_ASSERT(name, clk, rst, prop, msg)

`endif

FILE: design/bole_pkg.sv
`default_nettype none

package bole_pkg;

  // Width of the reported entry count.
  localparam int COUNT_W = 5;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_t;

  // Remove tests of an entry against the operand.
  typedef enum logic [1:0] {
    CMP_LESS    = 2'd0,
    CMP_EQUAL   = 2'd1,
    CMP_GREATER = 2'd2
  } cmp_mode_t;

  // One input item.
  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] operand;
    cmp_mode_t          compare_mode;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic               found;
    logic               rejected_full;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
  } result_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch operand and compare mode, restart the scan
    logic eq_only;    // membership query: compare for equality
    logic insert;     // write operand at the new head
    logic rd_en;      // read the entry at the scan position
    logic mark_hit;   // remember the hit position as the first write slot
    logic shift_wr;   // write the read entry one place toward the head
    logic dec;        // one entry fewer
    logic finish;     // register the result bits
    logic res_found;
    logic res_rej;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;       // list holds DEPTH entries
    logic more;       // scan position is below the count
    logic hit;        // registered entry passes the compare
    logic rd_vld;     // read data register holds a fresh entry
  } dp_status_t;

endpackage

`default_nettype wire

FILE: design/bole_datapath.sv
`default_nettype none

module bole_datapath #(
  parameter int DEPTH = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  bole_pkg::in_item_t    item,
  input  bole_pkg::ctrl_cmd_t   cmd,
  output bole_pkg::dp_status_t  status,
  output bole_pkg::result_t     result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int CNT_W = bole_pkg::COUNT_W;
  localparam logic [AW:0]   DEPTH_A = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  // Entries live in a circular buffer; position 0 sits at head.
  logic [31:0]         mem [DEPTH];
  logic [AW-1:0]       head;
  logic [CW-1:0]       count;
  logic [CW-1:0]       rd_pos;
  logic [CW-1:0]       wr_pos;
  logic                rd_vld;
  logic signed [31:0]  rdata;
  logic signed [31:0]  operand_q;
  bole_pkg::cmp_mode_t mode_q;
  logic                found_q;
  logic                rej_q;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [31:0]         wdata;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       head_dec;
  logic                cmp_ok;

  // List position to memory address, wrapping once past the end.
  function automatic logic [AW-1:0] pos_to_addr(input logic [AW-1:0] base,
                                                input logic [CW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, pos[AW-1:0]};
    if (sum >= DEPTH_A) begin
      sum = sum - DEPTH_A;
    end
    return sum[AW-1:0];
  endfunction

  // Write port: insert at the new head, or close the gap after a remove.
  always_comb begin
    head_dec = (head == '0) ? LAST_A : head - AW'(1);
    we       = cmd.insert | cmd.shift_wr;
    waddr    = cmd.insert ? head_dec : pos_to_addr(head, wr_pos);
    wdata    = cmd.insert ? item.operand : rdata;
    raddr    = pos_to_addr(head, rd_pos);
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // Operand and compare mode are held for the whole scan.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      operand_q <= item.operand;
      mode_q    <= cmd.eq_only ? bole_pkg::CMP_EQUAL : item.compare_mode;
    end
  end

  // List bookkeeping and scan pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      rd_pos  <= '0;
      wr_pos  <= '0;
      rd_vld  <= 1'b0;
      found_q <= 1'b0;
      rej_q   <= 1'b0;
    end else begin
      if (cmd.insert) begin
        head  <= head_dec;
        count <= count + CW'(1);
      end else if (cmd.dec) begin
        count <= count - CW'(1);
      end
      if (cmd.load) begin
        rd_pos <= '0;
        rd_vld <= 1'b0;
      end else begin
        rd_vld <= cmd.rd_en;
        if (cmd.rd_en) begin
          rd_pos <= rd_pos + CW'(1);
        end
      end
      if (cmd.mark_hit) begin
        wr_pos <= rd_pos - CW'(1);
      end else if (cmd.shift_wr) begin
        wr_pos <= wr_pos + CW'(1);
      end
      if (cmd.finish) begin
        found_q <= cmd.res_found;
        rej_q   <= cmd.res_rej;
      end
    end
  end

  // Signed compare of the registered entry against the operand.
  always_comb begin
    case (mode_q)
      bole_pkg::CMP_LESS:    cmp_ok = rdata < operand_q;
      bole_pkg::CMP_EQUAL:   cmp_ok = rdata == operand_q;
      bole_pkg::CMP_GREATER: cmp_ok = rdata > operand_q;
      default:               cmp_ok = 1'b0;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    status.full   = (count == DEPTH_C);
    status.more   = (rd_pos < count);
    status.hit    = rd_vld & cmp_ok;
    status.rd_vld = rd_vld;
  end

  // Result fields; the count register already holds the value after the item.
  always_comb begin
    result.found         = found_q;
    result.rejected_full = rej_q;
    result.entry_count   = CNT_W'(count);
    result.is_empty      = (count == '0);
  end

endmodule

`default_nettype wire

FILE: design/bole_controller.sv
`default_nettype none

module bole_controller (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  bole_pkg::in_item_t    item,
  input  bole_pkg::dp_status_t  status,
  output bole_pkg::ctrl_cmd_t   cmd,
  output logic                  busy,
  output logic                  done
);

  bole_pkg::ctrl_state_t state;
  bole_pkg::ctrl_state_t state_next;
  logic                  is_rem;
  logic                  is_rem_next;

  // State, operation kind and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bole_pkg::ST_IDLE;
      is_rem <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      is_rem <= is_rem_next;
      done   <= cmd.finish;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next  = state;
    is_rem_next = is_rem;
    cmd         = '0;
    busy        = (state != bole_pkg::ST_IDLE);
    unique case (state)
      bole_pkg::ST_IDLE: begin
        if (start) begin
          unique case (item.opcode)
            bole_pkg::OP_INSERT: begin
              cmd.finish  = 1'b1;
              cmd.res_rej = status.full;
              cmd.insert  = ~status.full;
            end
            bole_pkg::OP_QUERY: begin
              cmd.load    = 1'b1;
              cmd.eq_only = 1'b1;
              is_rem_next = 1'b0;
              state_next  = bole_pkg::ST_SCAN;
            end
            bole_pkg::OP_REMOVE: begin
              cmd.load    = 1'b1;
              is_rem_next = 1'b1;
              state_next  = bole_pkg::ST_SCAN;
            end
            default: begin
              cmd.finish = 1'b1;
            end
          endcase
        end
      end
      // One read issued and one entry checked per cycle.
      bole_pkg::ST_SCAN: begin
        cmd.rd_en = status.more;
        if (status.hit) begin
          if (is_rem) begin
            cmd.mark_hit = 1'b1;
            state_next   = bole_pkg::ST_SHIFT;
          end else begin
            cmd.finish    = 1'b1;
            cmd.res_found = 1'b1;
            state_next    = bole_pkg::ST_IDLE;
          end
        end else if (!status.more) begin
          cmd.finish = 1'b1;
          state_next = bole_pkg::ST_IDLE;
        end
      end
      // Move each later entry one place toward the head.
      bole_pkg::ST_SHIFT: begin
        cmd.rd_en    = status.more;
        cmd.shift_wr = status.rd_vld;
        if (!status.more && !status.rd_vld) begin
          cmd.dec       = 1'b1;
          cmd.finish    = 1'b1;
          cmd.res_found = 1'b1;
          state_next    = bole_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bole_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/bounded_ordered_list_engine.sv
// Ordered list of up to DEPTH signed 32-bit values, newest at the head.
// An item is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high, and cannot be held off, so the
// receiver must capture it in that cycle. Insert, accepted or rejected as
// full, leaves busy low, so inserts can follow every cycle. Query and remove
// walk the entry memory through its single read port, one entry per cycle: a
// query keeps busy high until a hit or until all held entries are checked; a
// remove stops at the first match and then moves every later entry one place
// toward the head. Nothing needs clearing after reset.
`default_nettype none

module bounded_ordered_list_engine #(
  parameter int DEPTH = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  bole_pkg::in_item_t  item,
  output logic                busy,
  output logic                done,
  output bole_pkg::result_t   result
);

  bole_pkg::ctrl_cmd_t  cmd;
  bole_pkg::dp_status_t status;

  // Sequencing of each operation.
  bole_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Entry memory, count and compare.
  bole_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule

`default_nettype wire

FILE: design/bole_checker.sv
`default_nettype none

`include "bounded_ordered_list_engine_macros.svh"

module bole_checker #(
  parameter int DEPTH = 16
) (
  input wire                 clk,
  input wire                 rst,
  input wire                 start,
  input bole_pkg::in_item_t  item,
  input wire                 busy,
  input wire                 done,
  input bole_pkg::result_t   result
);

  localparam int CNT_W = bole_pkg::COUNT_W;

  // An insert always reports in the very next cycle.
  `BOLE_ASSERT_CR(a_insert_one_cycle, start && !busy && item.opcode == bole_pkg::OP_INSERT |=> done, "insert result not in next cycle")

  // A result shows only after an accepted item or a running operation.
  `BOLE_ASSERT_CR(a_no_spurious_done, !busy && !start |=> !done, "result without an item")

  // The block is idle again when its result appears.
  `BOLE_ASSERT_CR(a_done_idle, done |-> !busy, "busy while showing a result")

  // A full rejection reports a full list and no find.
  `BOLE_ASSERT_CR(a_reject_full, done && result.rejected_full |-> !result.found && result.entry_count == CNT_W'(DEPTH), "rejection on a list that is not full")

endmodule

bind bounded_ordered_list_engine bole_checker #(.DEPTH(DEPTH)) u_bole_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .item   (item),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 24;

  // Tracks the list contents as items are accepted and holds the status
  // each one should report, oldest first.
  class list_tracker;
    logic signed [31:0] vals [DEPTH];
    int held;
    bole_pkg::result_t expected_status [$];
    int errors;
    int results_seen;

    function new();
      held = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    task complain(string msg);
      $display("MISMATCH at result %0d: %s", results_seen, msg);
      errors++;
    endtask

    function int pending();
      return expected_status.size();
    endfunction

    // Signed test of one entry against the operand for a remove.
    function bit passes(logic signed [31:0] entry, logic signed [31:0] opnd,
                        bole_pkg::cmp_mode_t mode);
      case (mode)
        bole_pkg::CMP_LESS:    return entry < opnd;
        bole_pkg::CMP_EQUAL:   return entry == opnd;
        bole_pkg::CMP_GREATER: return entry > opnd;
        default:               return 1'b0;
      endcase
    endfunction

    // Applies one operation to the tracked list and returns its status.
    function bole_pkg::result_t apply_op(bole_pkg::in_item_t it);
      bole_pkg::result_t r;
      logic signed [31:0] opnd;
      int i;
      int hit_at;
      r = '0;
      opnd = it.operand;
      hit_at = -1;
      case (it.opcode)
        bole_pkg::OP_INSERT: begin
          if (held >= DEPTH) begin
            r.rejected_full = 1'b1;
          end else begin
            for (i = held; i > 0; i--) vals[i] = vals[i-1];
            vals[0] = opnd;
            held++;
          end
        end
        bole_pkg::OP_QUERY: begin
          for (i = 0; i < held; i++) begin
            if (vals[i] == opnd) r.found = 1'b1;
          end
        end
        bole_pkg::OP_REMOVE: begin
          for (i = 0; i < held && hit_at < 0; i++) begin
            if (passes(vals[i], opnd, it.compare_mode)) hit_at = i;
          end
          if (hit_at >= 0) begin
            r.found = 1'b1;
            for (i = hit_at; i + 1 < held; i++) vals[i] = vals[i+1];
            held--;
          end
        end
        default: ;
      endcase
      r.entry_count = held[bole_pkg::COUNT_W-1:0];
      r.is_empty = (held == 0);
      return r;
    endfunction

    function void take_command(bole_pkg::in_item_t it);
      expected_status.push_back(apply_op(it));
    endfunction

    task match_result(bole_pkg::result_t got);
      bole_pkg::result_t want;
      results_seen++;
      if (expected_status.size() == 0) begin
        complain($sformatf("result %h arrived with nothing outstanding", got));
        return;
      end
      want = expected_status.pop_front();
      if (got.found !== want.found)
        complain($sformatf("found %b, expected %b", got.found, want.found));
      if (got.rejected_full !== want.rejected_full)
        complain($sformatf("rejected_full %b, expected %b",
                           got.rejected_full, want.rejected_full));
      if (got.entry_count !== want.entry_count)
        complain($sformatf("entry_count %0d, expected %0d",
                           got.entry_count, want.entry_count));
      if (got.is_empty !== want.is_empty)
        complain($sformatf("is_empty %b, expected %b", got.is_empty, want.is_empty));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  bole_pkg::in_item_t item = '0;
  logic busy;
  logic done;
  bole_pkg::result_t result;

  list_tracker tracker = new();
  int cycles = 0;
  int insert_bias = 60;

  bounded_ordered_list_engine #(.DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .done(done),
    .result(result)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results are checked before the item taken at the same edge is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.match_result(result);
      if (start && !busy) tracker.take_command(item);
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic bole_pkg::in_item_t make_item(logic [1:0] op,
                                                   logic signed [31:0] val,
                                                   logic [1:0] mode);
    bole_pkg::in_item_t it;
    it.opcode = bole_pkg::opcode_t'(op);
    it.operand = val;
    it.compare_mode = bole_pkg::cmp_mode_t'(mode);
    return it;
  endfunction

  // Operands cluster on small numbers and the extremes so that queries and
  // removes find matches often.
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return $signed($urandom_range(8)) - 4;
    if (sel < 7) begin
      case ($urandom_range(3))
        0: return 32'sh7FFFFFFF;
        1: return 32'sh80000000;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic bole_pkg::in_item_t random_item();
    int roll;
    logic [1:0] op;
    logic [1:0] mode;
    logic signed [31:0] val;
    roll = $urandom_range(99);
    if (roll < 2) op = 2'd3;
    else if (roll < insert_bias) op = bole_pkg::OP_INSERT;
    else if (roll < insert_bias + (100 - insert_bias) / 2) op = bole_pkg::OP_QUERY;
    else op = bole_pkg::OP_REMOVE;
    mode = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
    if (op != bole_pkg::OP_INSERT && tracker.held > 0 && $urandom_range(1) == 1)
      val = tracker.vals[$urandom_range(tracker.held - 1)];
    else
      val = pick_value();
    return make_item(op, val, mode);
  endfunction

  // Presents one item, optionally after a short gap, and returns at the
  // edge where it is taken.
  task automatic send_item(bole_pkg::in_item_t it, int gap_pct);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Holds off new items until every outstanding result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic run_random(int n, int gap_pct);
    int k;
    for (k = 0; k < n; k++) begin
      // Swing between filling and draining so both full and empty recur.
      if (k % 30 == 0) insert_bias = (insert_bias > 50) ? 22 : 75;
      send_item(random_item(), gap_pct);
    end
  endtask

  initial begin
    logic signed [31:0] fill_vals [DEPTH];
    int k;
    fill_vals = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh0, -32'sd1, 32'sd1, -32'sd2,
                  32'sd5, 32'sd5, 32'sd100, -32'sd100, 32'sh40000000,
                  32'shC0000000, 32'sd7, -32'sd7, 32'sd3, 32'sh12345678};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: operations on an empty list, a fill to capacity, an insert
    // dropped as full, hits and misses, every compare mode and the unused
    // opcode and compare mode.
    send_item(make_item(bole_pkg::OP_QUERY, 32'sh0, bole_pkg::CMP_EQUAL), 0);
    send_item(make_item(bole_pkg::OP_REMOVE, 32'sh0, bole_pkg::CMP_GREATER), 0);
    for (k = 0; k < DEPTH; k++)
      send_item(make_item(bole_pkg::OP_INSERT, fill_vals[k], bole_pkg::CMP_LESS), 0);
    send_item(make_item(bole_pkg::OP_INSERT, 32'sd9, bole_pkg::CMP_LESS), 0);
    send_item(make_item(bole_pkg::OP_QUERY, 32'sh80000000, bole_pkg::CMP_LESS), 0);
    send_item(make_item(bole_pkg::OP_QUERY, 32'sd999, bole_pkg::CMP_LESS), 0);
    send_item(make_item(bole_pkg::OP_REMOVE, 32'sh0, 2'd3), 0);
    send_item(make_item(bole_pkg::OP_REMOVE, 32'sd5, bole_pkg::CMP_EQUAL), 0);
    send_item(make_item(bole_pkg::OP_REMOVE, 32'sh0, bole_pkg::CMP_LESS), 0);
    send_item(make_item(bole_pkg::OP_REMOVE, 32'sh7FFFFFFF, bole_pkg::CMP_GREATER), 0);
    send_item(make_item(2'd3, 32'shFFFFFFFF, 2'd3), 0);
    wait_drained();

    // Random traffic: light sender gaps, then heavy, then none.
    run_random(250, 6);
    wait_drained();
    run_random(250, 49);
    wait_drained();
    run_random(250, 0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
